@@ design/mrq_pkg.sv @@
// Shared types, constants and helper functions for the multi-reader queue.
package mrq_pkg;

    // Storage sizing
    localparam int QUEUE_DEPTH = 256;
    localparam int MAX_READERS = 4;

    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int RIDX_W = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
    localparam int RCNT_W = $clog2(MAX_READERS + 1);

    // Field widths
    localparam int CMD_W     = 2;
    localparam int READER_W  = 2;
    localparam int PAYLOAD_W = 64;
    localparam int SEQ_W     = 32;
    localparam int ACTIVE_W  = 3;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 9;

    // Stream packing
    localparam int S_USED_W   = READER_W + PAYLOAD_W + SEQ_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;
    localparam int M_USED_W   = PAYLOAD_W + SEQ_W + COUNT_W + COUNT_W;
    localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;
    localparam int ENTRY_W    = PAYLOAD_W + SEQ_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 2'd0,
        CMD_READ    = 2'd1,
        CMD_ACK     = 2'd2,
        CMD_RECLAIM = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_NO_FREE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_RD_OLD,
        S_RD_OFF,
        S_RD_END,
        S_RD_MEM,
        S_RD_DATA,
        S_RC_MIN,
        S_RC_TGT,
        S_RC_CMP,
        S_RC_OLD,
        S_RC_D,
        S_DONE
    } t_state;

    // Request to and result from the shared 32-bit add/subtract unit
    typedef struct packed {
        logic             sub;
        logic [SEQ_W-1:0] a;
        logic [SEQ_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [SEQ_W-1:0] y;
        logic             borrow;
    } t_alu_res;

    // Circular slot add; a below depth and b at most depth
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                   input logic [CNT_W-1:0]  b);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - SLOT_W){1'b0}}, a} + {1'b0, b};
        if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
        end
        return sum[SLOT_W-1:0];
    endfunction

    function automatic logic reader_ok(input logic [READER_W-1:0] r);
        return int'(r) < MAX_READERS;
    endfunction

    // Active reader count clamped to one..MAX_READERS
    function automatic logic [RCNT_W-1:0] clamp_readers(input logic [ACTIVE_W-1:0] n);
        logic [RCNT_W-1:0] res;
        if (n == '0) begin
            res = RCNT_W'(1);
        end else if (int'(n) > MAX_READERS) begin
            res = RCNT_W'(MAX_READERS);
        end else begin
            res = RCNT_W'(n);
        end
        return res;
    endfunction

endpackage

@@ design/mrq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/mrq_alu.sv @@
// Shared 32-bit add/subtract unit used by the arithmetic steps of the sequencer.
module mrq_alu (
    input  mrq_pkg::t_alu_req i_req,
    output mrq_pkg::t_alu_res o_res
);
    import mrq_pkg::*;

    logic [SEQ_W:0] ext;

    // Subtract with borrow out, or add modulo 2^32
    always_comb begin
        if (i_req.sub) begin
            ext = {1'b0, i_req.a} - {1'b0, i_req.b};
        end else begin
            ext = {1'b0, i_req.a} + {1'b0, i_req.b};
        end
        o_res.y      = ext[SEQ_W-1:0];
        o_res.borrow = i_req.sub & ext[SEQ_W];
    end

endmodule

@@ design/multi_reader_queue_with_reclaim_top.sv @@
// Broadcast queue with per-reader positions and ack-gated reclaim.
// Each command steps a sequencer that shares one 32-bit add/subtract unit and reads the
// entry RAM through its registered read port; a reclaim visits each active reader in turn.
// One item at a time: the next item is accepted the cycle after its result is registered.
// Synchronous active-low reset clears counters, reader positions (to one), acks (to zero)
// and sets active_readers to one; the entry RAM is not cleared and needs no sweep.
module multi_reader_queue_with_reclaim_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input item stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mrq_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // reader, payload, ack_index
    input  logic [mrq_pkg::CMD_W-1:0]         s_axis_tuser,  // command
    // Result item stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mrq_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // read_data, read_sequence,
                                                             // entry_count, freed_count
    output logic [mrq_pkg::STATUS_W-1:0]      m_axis_tuser,  // status
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mrq_pkg::ACTIVE_W-1:0]      i_cfg_data     // active_readers
);
    import mrq_pkg::*;

    // Sequencer and input item
    t_state                r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [READER_W-1:0]   r_reader, n_reader;
    logic [PAYLOAD_W-1:0]  r_payload, n_payload;

    // Queue state
    logic [SLOT_W-1:0]     r_oldest, n_oldest;
    logic [CNT_W-1:0]      r_held, n_held;
    logic [SEQ_W-1:0]      r_last, n_last;
    logic [SEQ_W-1:0]      r_lfreed, n_lfreed;
    logic [SEQ_W-1:0]      r_next [MAX_READERS];
    logic [SEQ_W-1:0]      n_next [MAX_READERS];
    logic [SEQ_W-1:0]      r_acked [MAX_READERS];
    logic [SEQ_W-1:0]      n_acked [MAX_READERS];
    logic [ACTIVE_W-1:0]   r_active, n_active;

    // Working registers
    logic [SEQ_W-1:0]      r_tmp, n_tmp;
    logic [SEQ_W-1:0]      r_off, n_off;
    logic [SEQ_W-1:0]      r_tgt, n_tgt;
    logic [RCNT_W-1:0]     r_idx, n_idx;

    // Result of the item in progress
    t_status               r_st, n_st;
    logic [PAYLOAD_W-1:0]  r_dat, n_dat;
    logic [SEQ_W-1:0]      r_sq, n_sq;
    logic [CNT_W-1:0]      r_fr, n_fr;

    // Output register
    logic                  r_out_valid, n_out_valid;
    t_status               r_o_status, n_o_status;
    logic [PAYLOAD_W-1:0]  r_o_data, n_o_data;
    logic [SEQ_W-1:0]      r_o_seq, n_o_seq;
    logic [COUNT_W-1:0]    r_o_entry, n_o_entry;
    logic [COUNT_W-1:0]    r_o_freed, n_o_freed;

    // Shared unit and entry RAM
    t_alu_req              alu_req;
    t_alu_res              alu_res;
    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [SLOT_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;

    // Input field unpacking
    logic [READER_W-1:0]   in_reader;
    logic [PAYLOAD_W-1:0]  in_payload;
    logic [SEQ_W-1:0]      in_ack;
    logic [RIDX_W-1:0]     in_ridx;
    logic [RIDX_W-1:0]     cur_ridx;
    logic [RCNT_W-1:0]     n_readers;
    logic [CNT_W-1:0]      held_m1;
    logic [CNT_W-1:0]      freed;

    assign in_reader  = s_axis_tdata[READER_W-1:0];
    assign in_payload = s_axis_tdata[READER_W +: PAYLOAD_W];
    assign in_ack     = s_axis_tdata[READER_W + PAYLOAD_W +: SEQ_W];
    assign in_ridx    = RIDX_W'(in_reader);
    assign cur_ridx   = RIDX_W'(r_reader);
    assign n_readers  = clamp_readers(r_active);
    assign held_m1    = r_held - CNT_W'(1);

    mrq_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    mrq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state, shared-unit operands and register updates
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_reader    = r_reader;
        n_payload   = r_payload;
        n_oldest    = r_oldest;
        n_held      = r_held;
        n_last      = r_last;
        n_lfreed    = r_lfreed;
        n_next      = r_next;
        n_acked     = r_acked;
        n_active    = r_active;
        n_tmp       = r_tmp;
        n_off       = r_off;
        n_tgt       = r_tgt;
        n_idx       = r_idx;
        n_st        = r_st;
        n_dat       = r_dat;
        n_sq        = r_sq;
        n_fr        = r_fr;
        n_out_valid = r_out_valid;
        n_o_status  = r_o_status;
        n_o_data    = r_o_data;
        n_o_seq     = r_o_seq;
        n_o_entry   = r_o_entry;
        n_o_freed   = r_o_freed;
        freed       = '0;

        alu_req.sub = 1'b0;
        alu_req.a   = r_last;
        alu_req.b   = SEQ_W'(1);

        ram_we    = 1'b0;
        ram_waddr = slot_add(r_oldest, r_held);
        ram_wdata = {alu_res.y, r_payload};
        ram_raddr = slot_add(r_oldest, {1'b0, r_off[SLOT_W-1:0]});

        // Drop the output item once taken
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        // Take a configuration write
        if (i_cfg_valid) begin
            n_active = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd     = t_cmd'(s_axis_tuser);
                    n_reader  = in_reader;
                    n_payload = in_payload;
                    n_st      = ST_OK;
                    n_dat     = '0;
                    n_sq      = '0;
                    n_fr      = '0;
                    case (t_cmd'(s_axis_tuser))
                        CMD_PUSH: begin
                            n_state = S_PUSH;
                        end
                        CMD_READ: begin
                            if (!reader_ok(in_reader) || r_held == '0) begin
                                n_st    = ST_EMPTY;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_RD_OLD;
                            end
                        end
                        CMD_ACK: begin
                            if (reader_ok(in_reader)) begin
                                n_acked[in_ridx] = in_ack;
                            end
                            n_state = S_DONE;
                        end
                        CMD_RECLAIM: begin
                            n_tmp   = r_acked[0];
                            n_idx   = RCNT_W'(1);
                            n_state = S_RC_MIN;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // Append the entry under the next sequence number, or report a full queue
            S_PUSH: begin
                if (r_held >= CNT_W'(QUEUE_DEPTH)) begin
                    n_st = ST_FULL;
                end else begin
                    ram_we = 1'b1;
                    n_last = alu_res.y;
                    n_sq   = alu_res.y;
                    n_held = r_held + CNT_W'(1);
                end
                n_state = S_DONE;
            end

            // Oldest held sequence number
            S_RD_OLD: begin
                alu_req.sub = 1'b1;
                alu_req.a   = r_last;
                alu_req.b   = SEQ_W'(held_m1);
                n_tmp       = alu_res.y;
                n_state     = S_RD_OFF;
            end

            // Offset of the reader's position inside the window
            S_RD_OFF: begin
                alu_req.sub = 1'b1;
                alu_req.a   = r_next[cur_ridx];
                alu_req.b   = r_tmp;
                n_off       = alu_res.y;
                if (alu_res.y[SEQ_W-1:CNT_W] == '0 && alu_res.y[CNT_W-1:0] < r_held) begin
                    n_state = S_RD_MEM;
                end else begin
                    n_state = S_RD_END;
                end
            end

            // Caught up, or restart a stale reader at the oldest entry
            S_RD_END: begin
                alu_req.sub = 1'b1;
                alu_req.a   = r_next[cur_ridx];
                alu_req.b   = r_last;
                if (alu_res.y == SEQ_W'(1)) begin
                    n_st    = ST_EMPTY;
                    n_state = S_DONE;
                end else begin
                    n_off   = '0;
                    n_state = S_RD_MEM;
                end
            end

            // Issue the entry read
            S_RD_MEM: begin
                n_state = S_RD_DATA;
            end

            // Capture the entry and advance the reader
            S_RD_DATA: begin
                alu_req.sub = 1'b0;
                alu_req.a   = ram_rdata[PAYLOAD_W +: SEQ_W];
                alu_req.b   = SEQ_W'(1);
                n_dat       = ram_rdata[PAYLOAD_W-1:0];
                n_sq        = ram_rdata[PAYLOAD_W +: SEQ_W];
                n_next[cur_ridx] = alu_res.y;
                n_state     = S_DONE;
            end

            // Minimum ack, one reader per cycle
            S_RC_MIN: begin
                if (r_idx >= n_readers) begin
                    n_state = S_RC_TGT;
                end else begin
                    alu_req.sub = 1'b1;
                    alu_req.a   = r_acked[r_idx[RIDX_W-1:0]];
                    alu_req.b   = r_tmp;
                    if (alu_res.borrow) begin
                        n_tmp = r_acked[r_idx[RIDX_W-1:0]];
                    end
                    n_idx = r_idx + RCNT_W'(1);
                end
            end

            // Target is the minimum ack less one
            S_RC_TGT: begin
                alu_req.sub = 1'b1;
                alu_req.a   = r_tmp;
                alu_req.b   = SEQ_W'(1);
                n_tgt       = alu_res.y;
                if (r_tmp == '0) begin
                    n_st    = ST_NO_FREE;
                    n_state = S_DONE;
                end else begin
                    n_state = S_RC_CMP;
                end
            end

            // Target must pass the last freed number
            S_RC_CMP: begin
                alu_req.sub = 1'b1;
                alu_req.a   = r_lfreed;
                alu_req.b   = r_tgt;
                if (!alu_res.borrow) begin
                    n_st    = ST_NO_FREE;
                    n_state = S_DONE;
                end else if (r_held == '0) begin
                    n_lfreed = r_tgt;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_RC_OLD;
                end
            end

            S_RC_OLD: begin
                alu_req.sub = 1'b1;
                alu_req.a   = r_last;
                alu_req.b   = SEQ_W'(held_m1);
                n_tmp       = alu_res.y;
                n_state     = S_RC_D;
            end

            // Release up to the target, clamped to the held entries
            S_RC_D: begin
                alu_req.sub = 1'b1;
                alu_req.a   = r_tgt;
                alu_req.b   = r_tmp;
                if (!alu_res.y[SEQ_W-1]) begin
                    if (alu_res.y[SEQ_W-1:CNT_W] != '0 || alu_res.y[CNT_W-1:0] >= r_held) begin
                        freed = r_held;
                    end else begin
                        freed = alu_res.y[CNT_W-1:0] + CNT_W'(1);
                    end
                end
                n_oldest = slot_add(r_oldest, freed);
                n_held   = r_held - freed;
                n_fr     = freed;
                n_lfreed = r_tgt;
                n_state  = S_DONE;
            end

            // Move the result into the output register when free
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_st;
                    n_o_data    = r_dat;
                    n_o_seq     = r_sq;
                    n_o_entry   = COUNT_W'(r_held);
                    n_o_freed   = COUNT_W'(r_fr);
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_oldest    <= '0;
            r_held      <= '0;
            r_last      <= '0;
            r_lfreed    <= '0;
            r_active    <= ACTIVE_W'(1);
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_READERS; i++) begin
                r_next[i]  <= SEQ_W'(1);
                r_acked[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_held      <= n_held;
            r_last      <= n_last;
            r_lfreed    <= n_lfreed;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            r_next      <= n_next;
            r_acked     <= n_acked;
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_reader   <= n_reader;
        r_payload  <= n_payload;
        r_tmp      <= n_tmp;
        r_off      <= n_off;
        r_tgt      <= n_tgt;
        r_idx      <= n_idx;
        r_st       <= n_st;
        r_dat      <= n_dat;
        r_sq       <= n_sq;
        r_fr       <= n_fr;
        r_o_status <= n_o_status;
        r_o_data   <= n_o_data;
        r_o_seq    <= n_o_seq;
        r_o_entry  <= n_o_entry;
        r_o_freed  <= n_o_freed;
    end

    // Ports
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tdata  = {{(M_TDATA_W - M_USED_W){1'b0}},
                            r_o_freed, r_o_entry, r_o_seq, r_o_data};

    // Checks
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CNT_W'(QUEUE_DEPTH))
        else $error("held entry count above queue depth");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_status == ST_FULL) |-> r_o_entry == COUNT_W'(QUEUE_DEPTH))
        else $error("full status without a full queue");

    a_freed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_freed != '0) |-> r_o_status == ST_OK)
        else $error("entries freed with a failing status");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item accepted while one is in progress");

endmodule

@@ tb/multi_reader_queue_with_reclaim_top_tb.sv @@
// Testbench for the multi-reader broadcast queue: directed and random commands checked per item.
module multi_reader_queue_with_reclaim_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SEQ_LO   = PAYLOAD_W;
    localparam int CNT_LO   = PAYLOAD_W + SEQ_W;
    localparam int FREED_LO = PAYLOAD_W + SEQ_W + COUNT_W;

    typedef struct {
        t_status              status;
        logic [PAYLOAD_W-1:0] data;
        logic [SEQ_W-1:0]     seq;
        logic [COUNT_W-1:0]   count;
        logic [COUNT_W-1:0]   freed;
    } t_reply;

    // DUT connections
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [CMD_W-1:0]       s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [ACTIVE_W-1:0]    i_cfg_data = '0;

    // Queue model state
    logic [PAYLOAD_W-1:0]   word_mem [QUEUE_DEPTH];
    logic [SEQ_W-1:0]       seq_mem [QUEUE_DEPTH];
    int unsigned            head_slot;
    int unsigned            held_cnt;
    logic [SEQ_W-1:0]       newest_seq;
    logic [SEQ_W-1:0]       freed_upto;
    logic [SEQ_W-1:0]       next_seq [MAX_READERS];
    logic [SEQ_W-1:0]       acked_seq [MAX_READERS];
    logic [ACTIVE_W-1:0]    readers_cfg;

    t_reply                 awaited_replies[$];
    int                     errors = 0;
    int                     send_gap_pct = 0;
    int                     ready_stall_pct = 0;
    int                     idle_cycles = 0;

    multi_reader_queue_with_reclaim_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // reader, payload, ack_index
        .s_axis_tuser  (s_axis_tuser),   // command
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // read_data, read_sequence, entry_count, freed_count
        .m_axis_tuser  (m_axis_tuser),   // status
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)      // active_readers
    );

    always #2 i_clk = ~i_clk;

    // Clear the queue model to its post-reset state
    function automatic void reset_queue_model();
        head_slot   = 0;
        held_cnt    = 0;
        newest_seq  = '0;
        freed_upto  = '0;
        readers_cfg = ACTIVE_W'(1);
        for (int i = 0; i < MAX_READERS; i++) begin
            next_seq[i]  = SEQ_W'(1);
            acked_seq[i] = '0;
        end
    endfunction

    function automatic int gating_readers(input logic [ACTIVE_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        return (int'(v) > MAX_READERS) ? MAX_READERS : int'(v);
    endfunction

    // Apply one command to the queue model and return the reply it produces
    function automatic void compute_queue_reply(input t_cmd cmd, input logic [READER_W-1:0] rdr,
                                                input logic [PAYLOAD_W-1:0] pl,
                                                input logic [SEQ_W-1:0] ack, output t_reply r);
        logic [SEQ_W-1:0] oldest, nxt, off, lowest, target, span;
        int unsigned      slot, release_cnt;
        r.status = ST_OK;
        r.data   = '0;
        r.seq    = '0;
        r.freed  = '0;
        oldest   = newest_seq - SEQ_W'(held_cnt) + SEQ_W'(1);
        case (cmd)
            CMD_PUSH: begin
                if (held_cnt >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    slot = (head_slot + held_cnt) % QUEUE_DEPTH;
                    newest_seq = newest_seq + SEQ_W'(1);
                    word_mem[slot] = pl;
                    seq_mem[slot]  = newest_seq;
                    held_cnt++;
                    r.seq = newest_seq;
                end
            end
            CMD_READ: begin
                if (held_cnt == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    nxt = next_seq[rdr];
                    off = nxt - oldest;
                    // a position outside the window restarts at the oldest entry unless the reader is caught up
                    if (off >= held_cnt) begin
                        if (nxt == newest_seq + SEQ_W'(1)) begin
                            r.status = ST_EMPTY;
                        end else begin
                            off = '0;
                        end
                    end
                    if (r.status == ST_OK) begin
                        slot = (head_slot + off) % QUEUE_DEPTH;
                        r.data = word_mem[slot];
                        r.seq  = seq_mem[slot];
                        next_seq[rdr] = r.seq + SEQ_W'(1);
                    end
                end
            end
            CMD_ACK: begin
                acked_seq[rdr] = ack;
            end
            default: begin
                lowest = acked_seq[0];
                for (int i = 1; i < gating_readers(readers_cfg); i++) begin
                    if (acked_seq[i] < lowest) begin
                        lowest = acked_seq[i];
                    end
                end
                if (lowest == '0 || lowest - SEQ_W'(1) <= freed_upto) begin
                    r.status = ST_NO_FREE;
                end else begin
                    target = lowest - SEQ_W'(1);
                    release_cnt = 0;
                    if (held_cnt != 0) begin
                        span = target - oldest;
                        // a target half the number space ahead counts as behind the window
                        if (span < 32'h8000_0000) begin
                            release_cnt = (span >= held_cnt) ? held_cnt : int'(span) + 1;
                        end
                    end
                    head_slot  = (head_slot + release_cnt) % QUEUE_DEPTH;
                    held_cnt   = held_cnt - release_cnt;
                    freed_upto = target;
                    r.freed    = COUNT_W'(release_cnt);
                end
            end
        endcase
        r.count = COUNT_W'(held_cnt);
    endfunction

    // Send one item, idling first at random, and queue its expected reply
    task automatic send_command(input t_cmd cmd, input logic [READER_W-1:0] rdr,
                                input logic [PAYLOAD_W-1:0] pl, input logic [SEQ_W-1:0] ack);
        t_reply r;
        if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'({ack, pl, rdr});
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        compute_queue_reply(cmd, rdr, pl, ack, r);
        awaited_replies.push_back(r);
    endtask

    // Stop sending and wait until every reply is back
    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_readers(input logic [ACTIVE_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        readers_cfg = v;
    endtask

    // Mostly ack what the reader has consumed; sometimes lag, run ahead or send noise
    function automatic logic [SEQ_W-1:0] pick_ack(input logic [READER_W-1:0] rdr);
        logic [SEQ_W-1:0] consumed;
        int               mode, k;
        consumed = next_seq[rdr] - SEQ_W'(1);
        mode = $urandom_range(0, 9);
        k    = $urandom_range(0, 3);
        if (mode < 6) begin
            return consumed;
        end else if (mode < 8) begin
            return (consumed >= k) ? consumed - SEQ_W'(k) : consumed;
        end else if (mode == 8) begin
            return newest_seq + SEQ_W'($urandom_range(1, 6));
        end
        // keep reader zero sane so the minimum never runs away
        return (rdr != '0) ? SEQ_W'($urandom) : consumed;
    endfunction

    // Every command, field extremes and the corner cases of read and reclaim
    task automatic test_directed();
        send_gap_pct = 27;
        ready_stall_pct = 53;
        send_command(CMD_RECLAIM, 2'd0, '0, '0);               // zero minimum ack
        send_command(CMD_READ,    2'd0, '0, '0);               // empty queue
        send_command(CMD_PUSH,    2'd0, '0, '0);
        send_command(CMD_PUSH,    2'd1, '1, '0);
        send_command(CMD_PUSH,    2'd2, 64'hA5A5_5A5A_F00F_0FF0, '0);
        send_command(CMD_READ,    2'd0, '0, '0);
        send_command(CMD_READ,    2'd3, '0, '0);
        send_command(CMD_ACK,     2'd0, '0, 32'd2);
        send_command(CMD_RECLAIM, 2'd0, '0, '0);               // free the first entry
        send_command(CMD_READ,    2'd1, '0, '0);               // stale position restarts
        send_command(CMD_ACK,     2'd2, '0, 32'hFFFF_FFFF);    // not gating
        send_command(CMD_RECLAIM, 2'd3, '0, '0);               // target already freed
        send_command(CMD_ACK,     2'd0, '0, newest_seq + 32'd4);
        send_command(CMD_RECLAIM, 2'd0, '0, '0);               // release clamped to held
        send_command(CMD_READ,    2'd0, '0, '0);
        send_command(CMD_PUSH,    2'd3, 64'h0123_4567_89AB_CDEF, '1);
        send_command(CMD_READ,    2'd3, '0, '0);               // far behind, restart
        finish_phase();

        // a zero count gates on reader zero alone
        write_readers(3'd0);
        send_command(CMD_ACK,     2'd0, '0, 32'd9);
        send_command(CMD_RECLAIM, 2'd0, '0, '0);
        finish_phase();

        // a count above the reader limit gates on all readers
        write_readers(3'd7);
        for (int i = 0; i < MAX_READERS; i++) begin
            send_command(CMD_ACK, READER_W'(i), '0, 32'd12);
        end
        send_command(CMD_PUSH,    2'd0, 64'hDEAD_BEEF_CAFE_F00D, '0);
        send_command(CMD_RECLAIM, 2'd0, '0, '0);
        finish_phase();
    endtask

    // Fill the queue past its depth, then read, ack and drain it
    task automatic test_queue_full();
        int full_hits;
        write_readers(3'd2);
        full_hits = 0;
        while (full_hits < 3) begin
            if (held_cnt >= QUEUE_DEPTH) begin
                full_hits++;
            end
            send_command(CMD_PUSH, 2'($urandom), {$urandom, $urandom}, $urandom);
        end
        repeat (8) send_command(CMD_READ, 2'd0, '0, $urandom);
        repeat (5) send_command(CMD_READ, 2'd1, '0, $urandom);
        send_command(CMD_ACK, 2'd0, 64'($urandom), next_seq[0] - 32'd1);
        send_command(CMD_ACK, 2'd1, 64'($urandom), next_seq[1] - 32'd1);
        send_command(CMD_RECLAIM, 2'd1, '0, '0);
        send_command(CMD_PUSH, 2'd0, {$urandom, $urandom}, '0);
        send_command(CMD_ACK, 2'd0, '0, newest_seq + 32'd2);
        send_command(CMD_ACK, 2'd1, '0, newest_seq + 32'd2);
        send_command(CMD_RECLAIM, 2'd0, '0, '0);
        send_command(CMD_READ, 2'd0, '0, '0);
        finish_phase();
    endtask

    // Random mix of pushes, reads, acks and reclaims under one reader count
    task automatic test_random_traffic(input logic [ACTIVE_W-1:0] cfg, input int gap,
                                       input int stall, input int count);
        t_cmd                 cmd;
        logic [READER_W-1:0]  rdr;
        logic [SEQ_W-1:0]     ack;
        int                   sel, eff;
        send_gap_pct = gap;
        ready_stall_pct = stall;
        write_readers(cfg);
        eff = gating_readers(cfg);
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            rdr = ($urandom_range(0, 4) != 0) ? READER_W'($urandom_range(0, eff - 1))
                                               : READER_W'($urandom_range(0, 3));
            ack = $urandom;
            if (sel < 25) begin
                cmd = CMD_PUSH;
            end else if (sel < 65) begin
                cmd = CMD_READ;
            end else if (sel < 85) begin
                cmd = CMD_ACK;
                ack = pick_ack(rdr);
            end else begin
                cmd = CMD_RECLAIM;
            end
            send_command(cmd, rdr, {$urandom, $urandom}, ack);
        end
        finish_phase();
    endtask

    // Acks far ahead land behind the window: nothing is released, then nothing is left to free
    task automatic test_far_ack();
        send_gap_pct = 0;
        ready_stall_pct = 0;
        write_readers(3'd4);
        repeat (4) send_command(CMD_PUSH, 2'd0, {$urandom, $urandom}, '0);
        for (int i = 0; i < MAX_READERS; i++) begin
            send_command(CMD_ACK, READER_W'(i), '0, 32'h9000_0000 + $urandom_range(0, 4095));
        end
        send_command(CMD_RECLAIM, 2'd0, '0, '0);
        send_command(CMD_RECLAIM, 2'd0, '0, '0);
        finish_phase();
        write_readers(3'd6);
        send_command(CMD_READ, 2'd2, '0, '0);
        send_command(CMD_PUSH, 2'd1, {$urandom, $urandom}, '0);
        send_command(CMD_READ, 2'd2, '0, '0);
        send_command(CMD_RECLAIM, 2'd3, '0, '0);
        finish_phase();
    endtask

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Check each reply against the oldest expectation; stall the result stream at random
    always @(posedge i_clk) begin : check_replies
        t_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_replies.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected reply, expected none, actual status %0d data %h",
                         $time, m_axis_tuser, m_axis_tdata);
            end else begin
                want = awaited_replies.pop_front();
                report_field("status", 64'(want.status), 64'(m_axis_tuser));
                report_field("read_data", want.data, m_axis_tdata[PAYLOAD_W-1:0]);
                report_field("read_sequence", 64'(want.seq), 64'(m_axis_tdata[SEQ_LO +: SEQ_W]));
                report_field("entry_count", 64'(want.count),
                             64'(m_axis_tdata[CNT_LO +: COUNT_W]));
                report_field("freed_count", 64'(want.freed),
                             64'(m_axis_tdata[FREED_LO +: COUNT_W]));
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= ready_stall_pct);
    end

    // End the run when no item moves on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        reset_queue_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_queue_full();
        test_random_traffic(3'd3, 27, 53, 500);
        test_random_traffic(3'd5, 53, 27, 500);
        test_random_traffic(3'd1, 0, 0, 500);
        test_far_ack();
        if (errors == 0 && awaited_replies.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/mrq_pkg.sv
design/mrq_ram.sv
design/mrq_alu.sv
design/multi_reader_queue_with_reclaim_top.sv
tb/multi_reader_queue_with_reclaim_top_tb.sv
